>>> sv/bfid_pkg.sv
// Shared types, constants and decode functions for the instruction window decoder.
// Depends on nothing; every other file of the block uses it.

package bfid_pkg;

    localparam int unsigned WINDOW_BYTES_DEF = 256;
    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam int unsigned CNT_W            = 9;
    localparam int unsigned ADDR_W           = 32;
    localparam logic [CNT_W-1:0] CNT_MAX     = '1;

    localparam logic [7:0] CH_OPEN  = 8'h5b;
    localparam logic [7:0] CH_CLOSE = 8'h5d;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h00;
    localparam logic [7:0] CH_ONES  = 8'hff;

    typedef enum logic [3:0] {
        SCAN_SEARCH = 4'b0001,
        SCAN_MATCH  = 4'b0010,
        SCAN_ILL    = 4'b0100,
        SCAN_STOP   = 4'b1000
    } t_scan_state;

    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_OPEN    = 4'd1,
        OP_CLOSE   = 4'd2,
        OP_PTR_INC = 4'd3,
        OP_PTR_DEC = 4'd4,
        OP_CEL_INC = 4'd5,
        OP_CEL_DEC = 4'd6,
        OP_OUT     = 4'd7,
        OP_IN      = 4'd8,
        OP_TRAP    = 4'd9,
        OP_ILLEGAL = 4'd10
    } t_op_kind;

    // Summary of one finished window, handed from the scanner to the decoder.
    typedef struct packed {
        logic [7:0]        lead_byte;
        logic [ADDR_W-1:0] base_address;
        logic [CNT_W-1:0]  run_count;
        t_scan_state       scan_state;
        logic [ADDR_W-1:0] jump_address;
    } t_win_sum;

    function automatic logic [3:0] key_of(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            CH_OPEN:  k = 4'd1;
            CH_CLOSE: k = 4'd2;
            CH_LT:    k = 4'd3;
            CH_GT:    k = 4'd4;
            CH_PLUS:  k = 4'd5;
            CH_MINUS: k = 4'd6;
            CH_COMMA: k = 4'd7;
            CH_DOT:   k = 4'd8;
            default:  k = 4'd0;
        endcase
        return k;
    endfunction

    function automatic t_op_kind kind_of(input logic [7:0] c);
        t_op_kind k;
        unique case (c)
            CH_OPEN:          k = OP_OPEN;
            CH_CLOSE:         k = OP_CLOSE;
            CH_GT:            k = OP_PTR_INC;
            CH_LT:            k = OP_PTR_DEC;
            CH_PLUS:          k = OP_CEL_INC;
            CH_MINUS:         k = OP_CEL_DEC;
            CH_DOT:           k = OP_OUT;
            CH_COMMA:         k = OP_IN;
            CH_ZERO, CH_ONES: k = OP_TRAP;
            default:          k = OP_NOP;
        endcase
        return k;
    endfunction

endpackage

>>> sv/bfid_front.sv
// Window scanner: accepts program bytes, tracks run length and bracket depth.
// Depends on bfid_pkg; pushes one window summary per last byte into the queue.

module bfid_front #(
    parameter int unsigned WINDOW_BYTES = bfid_pkg::WINDOW_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_code_byte,
    input  logic [31:0]        i_op_address,
    input  logic               i_last_byte,
    output logic               o_push,
    output bfid_pkg::t_win_sum o_sum
);

    localparam int unsigned POS_W = $clog2(WINDOW_BYTES + 1);
    localparam logic [POS_W-1:0] POS_END = POS_W'(WINDOW_BYTES);

    logic                        r_in_window, n_in_window;
    logic [7:0]                  r_lead, n_lead;
    logic [31:0]                 r_base, n_base;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic [bfid_pkg::CNT_W-1:0]  r_run, n_run;
    logic                        r_run_open, n_run_open;
    logic [bfid_pkg::CNT_W-1:0]  r_depth, n_depth;
    bfid_pkg::t_scan_state       r_scan, n_scan;
    logic [31:0]                 r_next_addr, n_next_addr;
    logic [31:0]                 r_jump, n_jump;
    logic [bfid_pkg::CNT_W-1:0]  w_depth_dec;

    assign w_depth_dec = (r_depth != '0) ? r_depth - 1'b1 : r_depth;

    always_comb begin
        n_in_window = r_in_window;
        n_lead      = r_lead;
        n_base      = r_base;
        n_pos       = r_pos;
        n_run       = r_run;
        n_run_open  = r_run_open;
        n_depth     = r_depth;
        n_scan      = r_scan;
        n_next_addr = r_next_addr;
        n_jump      = r_jump;
        if (i_accept) begin
            n_in_window = !i_last_byte;
            if (!r_in_window) begin
                n_lead      = i_code_byte;
                n_base      = i_op_address;
                n_pos       = POS_W'(1);
                n_run       = bfid_pkg::CNT_W'(1);
                n_run_open  = 1'b1;
                n_depth     = bfid_pkg::CNT_W'(1);
                n_scan      = bfid_pkg::SCAN_SEARCH;
                n_next_addr = i_op_address + 32'd2;
                n_jump      = '0;
            end else if (r_pos < POS_END) begin
                if (r_run_open) begin
                    if (i_code_byte == r_lead) begin
                        if (r_run != bfid_pkg::CNT_MAX) begin
                            n_run = r_run + 1'b1;
                        end
                    end else begin
                        n_run_open = 1'b0;
                    end
                end
                if (r_lead == bfid_pkg::CH_OPEN && r_scan == bfid_pkg::SCAN_SEARCH) begin
                    priority if (i_code_byte == bfid_pkg::CH_OPEN) begin
                        if (r_depth != bfid_pkg::CNT_MAX) begin
                            n_depth = r_depth + 1'b1;
                        end
                    end else if (i_code_byte == bfid_pkg::CH_CLOSE) begin
                        n_depth = w_depth_dec;
                        if (w_depth_dec == '0) begin
                            n_scan = bfid_pkg::SCAN_MATCH;
                            n_jump = r_next_addr;
                        end
                    end else if (i_code_byte == bfid_pkg::CH_ZERO) begin
                        n_scan = bfid_pkg::SCAN_STOP;
                    end else if (i_code_byte == bfid_pkg::CH_ONES) begin
                        n_scan = bfid_pkg::SCAN_ILL;
                    end else begin
                        n_scan = r_scan;
                    end
                end
                n_pos       = r_pos + 1'b1;
                n_next_addr = r_next_addr + 32'd1;
            end
        end
    end

    assign o_push             = i_accept && i_last_byte;
    assign o_sum.lead_byte    = n_lead;
    assign o_sum.base_address = n_base;
    assign o_sum.run_count    = n_run;
    assign o_sum.scan_state   = n_scan;
    assign o_sum.jump_address = n_jump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_window <= 1'b0;
            r_scan      <= bfid_pkg::SCAN_SEARCH;
        end else begin
            r_in_window <= n_in_window;
            r_scan      <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead      <= n_lead;
        r_base      <= n_base;
        r_pos       <= n_pos;
        r_run       <= n_run;
        r_run_open  <= n_run_open;
        r_depth     <= n_depth;
        r_next_addr <= n_next_addr;
        r_jump      <= n_jump;
    end

endmodule

>>> sv/bfid_queue.sv
// Short queue of window summaries between the scanner and the decoder.
// Depends on bfid_pkg for the summary type and the queue depth.

module bfid_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bfid_pkg::t_win_sum i_sum,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output bfid_pkg::t_win_sum o_sum
);

    localparam int unsigned PTR_W = $clog2(bfid_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_Q = $clog2(bfid_pkg::QUEUE_DEPTH + 1);

    bfid_pkg::t_win_sum r_mem [bfid_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_Q-1:0]   r_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == CNT_Q'(bfid_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_sum   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(bfid_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(bfid_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/bfid_back.sv
// Decoder: turns a window summary into the instruction word and holds it for output.
// Depends on bfid_pkg for the summary type, op kinds and decode functions.

module bfid_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bfid_pkg::t_win_sum i_sum,
    output logic               o_pop,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [3:0]         o_op_kind,
    output logic [3:0]         o_key_index,
    output logic [8:0]         o_op_length,
    output logic               o_match_found,
    output logic [31:0]        o_jump_target,
    output logic [31:0]        o_fall_target
);

    logic                r_valid;
    bfid_pkg::t_op_kind  r_kind, n_kind;
    logic [3:0]          r_key;
    logic [8:0]          r_len, n_len;
    logic                r_found, n_found;
    logic [31:0]         r_jump, n_jump;
    logic [31:0]         r_fall, n_fall;

    assign o_pop = i_valid && (!r_valid || i_out_ready);

    always_comb begin
        n_kind  = bfid_pkg::kind_of(i_sum.lead_byte);
        n_len   = 9'd1;
        n_found = 1'b0;
        n_jump  = '0;
        n_fall  = '0;
        unique case (n_kind)
            bfid_pkg::OP_OPEN: begin
                n_fall = i_sum.base_address + 32'd1;
                if (i_sum.scan_state == bfid_pkg::SCAN_MATCH) begin
                    n_found = 1'b1;
                    n_jump  = i_sum.jump_address;
                end else if (i_sum.scan_state == bfid_pkg::SCAN_ILL) begin
                    n_kind = bfid_pkg::OP_ILLEGAL;
                end
            end
            bfid_pkg::OP_PTR_INC, bfid_pkg::OP_PTR_DEC,
            bfid_pkg::OP_CEL_INC, bfid_pkg::OP_CEL_DEC: begin
                n_len = i_sum.run_count;
            end
            default: begin
                n_len = 9'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= n_kind;
            r_key   <= bfid_pkg::key_of(i_sum.lead_byte);
            r_len   <= n_len;
            r_found <= n_found;
            r_jump  <= n_jump;
            r_fall  <= n_fall;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_op_kind     = r_kind;
    assign o_key_index   = r_key;
    assign o_op_length   = r_len;
    assign o_match_found = r_found;
    assign o_jump_target = r_jump;
    assign o_fall_target = r_fall;

endmodule

>>> sv/bf_instruction_window_decoder_unit.sv
// Top level of the instruction window decoder: scanner, summary queue and decoder.
// Depends on bfid_pkg, bfid_front, bfid_queue and bfid_back.

// The block takes one program byte per cycle; the first word of a window carries the
// instruction address and the word with tlast closes the window. The scanner keeps the run
// length, the bracket depth and the running jump address in registers. A closed window is
// written into a two-entry queue and then into the registered decoder, so its decoded word
// is presented only after both registers and is held there while the output stalls;
// one-byte windows sustain one word per cycle while the output is ready. The input stalls
// only while the queue holds two undelivered windows.

module bf_instruction_window_decoder_unit #(
    parameter int unsigned WINDOW_BYTES = bfid_pkg::WINDOW_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [7:0] code_byte, [39:8] op_address
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // [3:0] key_index, [12:4] op_length, [13] match_found,
                                       // [45:14] jump_target, [77:46] fall_target, [79:78] zero
    output logic [3:0]  m_axis_tuser   // op_kind
);

    logic               w_accept;
    logic               w_push;
    logic               w_q_full;
    logic               w_q_valid;
    logic               w_pop;
    bfid_pkg::t_win_sum w_sum_in;
    bfid_pkg::t_win_sum w_sum_out;
    logic [3:0]         w_key;
    logic [8:0]         w_len;
    logic               w_found;
    logic [31:0]        w_jump;
    logic [31:0]        w_fall;

    assign s_axis_tready = !w_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    bfid_front #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_code_byte  (s_axis_tdata[7:0]),
        .i_op_address (s_axis_tdata[39:8]),
        .i_last_byte  (s_axis_tlast),
        .o_push       (w_push),
        .o_sum        (w_sum_in)
    );

    bfid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_sum   (w_sum_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_sum   (w_sum_out)
    );

    bfid_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_sum         (w_sum_out),
        .o_pop         (w_pop),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_op_kind     (m_axis_tuser),
        .o_key_index   (w_key),
        .o_op_length   (w_len),
        .o_match_found (w_found),
        .o_jump_target (w_jump),
        .o_fall_target (w_fall)
    );

    assign m_axis_tdata = {2'b00, w_fall, w_jump, w_found, w_len, w_key};

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("Window summary pushed into a full queue.");

    a_match_is_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_found |-> m_axis_tuser == bfid_pkg::OP_OPEN)
        else $error("Match reported for an instruction that is not an open bracket.");

    a_targets_only_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != bfid_pkg::OP_OPEN
            && m_axis_tuser != bfid_pkg::OP_ILLEGAL |-> w_jump == '0 && w_fall == '0)
        else $error("Branch targets set for a non-bracket instruction.");

    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_len != '0)
        else $error("Decoded instruction with zero length.");

endmodule

>>> sim/bfid_window_monitor.sv
// Monitor for the instruction window decoder: follows both stream channels, predicts every
// decoded word from the accepted program bytes and compares it field by field.
// Depends on bfid_pkg for the opcode characters, scan states and kind codes.
`timescale 1ns / 100ps

module bfid_window_monitor #(
    parameter int unsigned WINDOW_BYTES = bfid_pkg::WINDOW_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,  // [7:0] code_byte, [39:8] op_address
    input  logic        i_s_tlast,  // last_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,  // [3:0] key_index, [12:4] op_length, [13] match_found,
                                    // [45:14] jump_target, [77:46] fall_target, [79:78] zero
    input  logic [3:0]  i_m_tuser,  // op_kind
    output int          o_error_count,
    output int          o_pending
);

    typedef struct packed {
        bfid_pkg::t_op_kind          kind;
        logic [3:0]                  key;
        logic [bfid_pkg::CNT_W-1:0]  len;
        logic                        found;
        logic [bfid_pkg::ADDR_W-1:0] jump;
        logic [bfid_pkg::ADDR_W-1:0] fall;
    } t_decoded;

    logic [7:0]                  lead;
    logic [bfid_pkg::ADDR_W-1:0] base;
    logic                        open_win;
    int unsigned                 pos;
    logic [bfid_pkg::CNT_W-1:0]  run_len;
    logic                        run_live;
    logic [bfid_pkg::CNT_W-1:0]  depth;
    bfid_pkg::t_scan_state       scan;
    int unsigned                 match_pos;
    t_decoded                    decoded_q[$];

    task automatic note_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_error_count++;
    endtask

    function automatic t_decoded decode_window();
        t_decoded d;
        d = '0;
        d.len = bfid_pkg::CNT_W'(1);
        case (lead)
            bfid_pkg::CH_OPEN: begin
                d.kind = (scan == bfid_pkg::SCAN_ILL) ? bfid_pkg::OP_ILLEGAL
                                                      : bfid_pkg::OP_OPEN;
                d.key  = 4'd1;
                d.fall = base + 32'd1;
                if (scan == bfid_pkg::SCAN_MATCH) begin
                    d.found = 1'b1;
                    d.jump  = base + match_pos + 32'd1;
                end
            end
            bfid_pkg::CH_CLOSE: begin
                d.kind = bfid_pkg::OP_CLOSE;
                d.key  = 4'd2;
            end
            bfid_pkg::CH_LT: begin
                d.kind = bfid_pkg::OP_PTR_DEC;
                d.key  = 4'd3;
                d.len  = run_len;
            end
            bfid_pkg::CH_GT: begin
                d.kind = bfid_pkg::OP_PTR_INC;
                d.key  = 4'd4;
                d.len  = run_len;
            end
            bfid_pkg::CH_PLUS: begin
                d.kind = bfid_pkg::OP_CEL_INC;
                d.key  = 4'd5;
                d.len  = run_len;
            end
            bfid_pkg::CH_MINUS: begin
                d.kind = bfid_pkg::OP_CEL_DEC;
                d.key  = 4'd6;
                d.len  = run_len;
            end
            bfid_pkg::CH_COMMA: begin
                d.kind = bfid_pkg::OP_IN;
                d.key  = 4'd7;
            end
            bfid_pkg::CH_DOT: begin
                d.kind = bfid_pkg::OP_OUT;
                d.key  = 4'd8;
            end
            bfid_pkg::CH_ZERO, bfid_pkg::CH_ONES: begin
                d.kind = bfid_pkg::OP_TRAP;
            end
            default: begin
                d.kind = bfid_pkg::OP_NOP;
            end
        endcase
        return d;
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic [bfid_pkg::ADDR_W-1:0] addr,
                               input logic last);
        if (!open_win) begin
            open_win  = 1'b1;
            lead      = b;
            base      = addr;
            pos       = 1;
            run_len   = bfid_pkg::CNT_W'(1);
            run_live  = 1'b1;
            depth     = bfid_pkg::CNT_W'(1);
            scan      = bfid_pkg::SCAN_SEARCH;
            match_pos = 0;
        end else if (pos < WINDOW_BYTES) begin
            if (run_live) begin
                if (b == lead) begin
                    if (run_len != bfid_pkg::CNT_MAX) begin
                        run_len++;
                    end
                end else begin
                    run_live = 1'b0;
                end
            end
            if (lead == bfid_pkg::CH_OPEN && scan == bfid_pkg::SCAN_SEARCH) begin
                if (b == bfid_pkg::CH_OPEN) begin
                    if (depth != bfid_pkg::CNT_MAX) begin
                        depth++;
                    end
                end else if (b == bfid_pkg::CH_CLOSE) begin
                    if (depth != '0) begin
                        depth--;
                    end
                    if (depth == '0) begin
                        scan      = bfid_pkg::SCAN_MATCH;
                        match_pos = pos;
                    end
                end else if (b == bfid_pkg::CH_ZERO) begin
                    scan = bfid_pkg::SCAN_STOP;
                end else if (b == bfid_pkg::CH_ONES) begin
                    scan = bfid_pkg::SCAN_ILL;
                end
            end
            pos++;
        end
        if (last) begin
            open_win = 1'b0;
            decoded_q.push_back(decode_window());
        end
    endtask

    task automatic retire_word(input logic [79:0] data, input logic [3:0] user);
        t_decoded e;
        if (decoded_q.size() == 0) begin
            note_error("decoded word with none outstanding", 32'(user), 32'd0);
            return;
        end
        e = decoded_q.pop_front();
        if (user != e.kind) note_error("op_kind", 32'(user), 32'(e.kind));
        if (data[3:0] != e.key) note_error("key_index", 32'(data[3:0]), 32'(e.key));
        if (data[12:4] != e.len) note_error("op_length", 32'(data[12:4]), 32'(e.len));
        if (data[13] != e.found) note_error("match_found", 32'(data[13]), 32'(e.found));
        if (data[45:14] != e.jump) note_error("jump_target", data[45:14], e.jump);
        if (data[77:46] != e.fall) note_error("fall_target", data[77:46], e.fall);
        if (data[79:78] != 2'b00) note_error("tdata padding", 32'(data[79:78]), 32'd0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_win      = 1'b0;
            lead          = '0;
            base          = '0;
            pos           = 0;
            run_len       = '0;
            run_live      = 1'b0;
            depth         = '0;
            scan          = bfid_pkg::SCAN_SEARCH;
            match_pos     = 0;
            o_error_count = 0;
            decoded_q.delete();
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                retire_word(i_m_tdata, i_m_tuser);
            end
            if (i_s_tvalid && i_s_tready) begin
                absorb_byte(i_s_tdata[7:0], i_s_tdata[39:8], i_s_tlast);
            end
            o_pending <= decoded_q.size();
        end
    end

endmodule

>>> sim/tb.sv
// Top of the instruction window decoder testbench: clock, reset, program byte stimulus and
// random output stalls. Depends on bfid_pkg, the block and bfid_window_monitor.
`timescale 1ns / 100ps

module tb;

    localparam int         RANDOM_BYTES   = 110;
    localparam int         WATCHDOG_LIMIT = 500;
    localparam int         DRAIN_CYCLES   = 20;
    localparam logic [7:0] CH_PLAIN       = 8'h41;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // [7:0] code_byte, [39:8] op_address
    logic        s_axis_tlast  = 1'b0;  // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;  // [3:0] key_index, [12:4] op_length, [13] match_found,
                                // [45:14] jump_target, [77:46] fall_target, [79:78] zero
    logic [3:0]  m_axis_tuser;  // op_kind

    int         error_count;
    int         pending;
    int         bytes_sent   = 0;
    int         windows_sent = 0;
    int         idle_cycles  = 0;
    int         stall_left   = 0;
    logic       tx_gaps      = 1'b1;
    logic       rx_stalls    = 1'b1;
    logic [7:0] prog_q[$];

    bf_instruction_window_decoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bfid_window_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(1, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[bf_instruction_window_decoder_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] pick_code(input logic rough);
        int r;
        r = $urandom_range(0, 19);
        if (rough && r < 2) return bfid_pkg::CH_ZERO;
        if (rough && r < 4) return bfid_pkg::CH_ONES;
        if (rough && r < 6) return 8'($urandom);
        case ($urandom_range(0, 7))
            0:       return bfid_pkg::CH_OPEN;
            1:       return bfid_pkg::CH_CLOSE;
            2:       return bfid_pkg::CH_LT;
            3:       return bfid_pkg::CH_GT;
            4:       return bfid_pkg::CH_PLUS;
            5:       return bfid_pkg::CH_MINUS;
            6:       return bfid_pkg::CH_COMMA;
            default: return bfid_pkg::CH_DOT;
        endcase
    endfunction

    function automatic void add_run(input logic [7:0] c, input int n);
        repeat (n) prog_q.push_back(c);
    endfunction

    task automatic drive_byte(input logic [7:0] b, input logic [31:0] addr, input logic last);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {addr, b};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_program(input logic [31:0] addr);
        int i;
        for (i = 0; i < prog_q.size(); i++) begin
            drive_byte(prog_q[i], (i == 0) ? addr : $urandom, i == prog_q.size() - 1);
        end
        windows_sent++;
        prog_q.delete();
    endtask

    initial begin : stimulus
        logic [7:0] singles[11];
        logic [7:0] run_ops[4];
        logic [7:0] c;
        int         rand_start;
        int         depth;
        int         r;

        singles = '{bfid_pkg::CH_OPEN, bfid_pkg::CH_CLOSE, bfid_pkg::CH_LT, bfid_pkg::CH_GT,
                    bfid_pkg::CH_PLUS, bfid_pkg::CH_MINUS, bfid_pkg::CH_COMMA,
                    bfid_pkg::CH_DOT, bfid_pkg::CH_ZERO, bfid_pkg::CH_ONES, CH_PLAIN};
        run_ops = '{bfid_pkg::CH_GT, bfid_pkg::CH_LT, bfid_pkg::CH_PLUS, bfid_pkg::CH_MINUS};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (singles[k]) begin
            prog_q.push_back(singles[k]);
            send_program($urandom);
        end
        prog_q = '{bfid_pkg::CH_OPEN, bfid_pkg::CH_CLOSE};
        send_program(32'hffff_ffff);
        prog_q = '{bfid_pkg::CH_OPEN, bfid_pkg::CH_OPEN, bfid_pkg::CH_CLOSE, bfid_pkg::CH_CLOSE};
        send_program(32'h0000_0000);
        prog_q = '{bfid_pkg::CH_OPEN, bfid_pkg::CH_PLUS, bfid_pkg::CH_ZERO, bfid_pkg::CH_CLOSE};
        send_program($urandom);
        prog_q = '{bfid_pkg::CH_OPEN, bfid_pkg::CH_MINUS, bfid_pkg::CH_ONES, bfid_pkg::CH_CLOSE};
        send_program($urandom);
        prog_q = '{bfid_pkg::CH_PLUS, bfid_pkg::CH_PLUS, bfid_pkg::CH_PLUS, bfid_pkg::CH_GT};
        send_program($urandom);

        // A window at the scan limit: the close bracket lands on the last scanned byte and
        // one more follows beyond it.
        prog_q.push_back(bfid_pkg::CH_OPEN);
        add_run(bfid_pkg::CH_DOT, bfid_pkg::WINDOW_BYTES_DEF - 2);
        add_run(bfid_pkg::CH_CLOSE, 2);
        send_program($urandom);

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES) begin
            if (bytes_sent - rand_start > RANDOM_BYTES * 17 / 20) begin
                tx_gaps = 1'b0;
                rx_stalls <= 1'b0;
            end else begin
                if ($urandom_range(0, 9) == 0) tx_gaps = !tx_gaps;
                if ($urandom_range(0, 9) == 0) rx_stalls <= !rx_stalls;
            end
            r = $urandom_range(0, 19);
            if (r < 7) begin
                prog_q.push_back(bfid_pkg::CH_OPEN);
                depth = 1;
                repeat ($urandom_range(0, 12)) begin
                    c = pick_code($urandom_range(0, 7) == 0);
                    if (c == bfid_pkg::CH_OPEN) begin
                        depth++;
                    end else if (c == bfid_pkg::CH_CLOSE && depth > 0) begin
                        depth--;
                    end
                    prog_q.push_back(c);
                end
                if ($urandom_range(0, 3) != 0) add_run(bfid_pkg::CH_CLOSE, depth);
                repeat ($urandom_range(0, 2)) prog_q.push_back(pick_code(1'b1));
            end else if (r < 13) begin
                add_run(run_ops[$urandom_range(0, 3)], $urandom_range(1, 20));
                repeat ($urandom_range(0, 4)) prog_q.push_back(pick_code(1'b1));
            end else if (r < 17) begin
                prog_q.push_back(pick_code(1'b1));
            end else begin
                repeat ($urandom_range(1, 8)) prog_q.push_back(8'($urandom));
            end
            send_program($urandom);
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d windows in %0d bytes: every opcode alone, nested and unmatched",
                 windows_sent, bytes_sent);
        $display("bracket scans, runs, a window at the scan limit and noise, with idle bursts.");
        if (error_count == 0) begin
            $display("[bf_instruction_window_decoder_unit] OK");
        end else begin
            $display("[bf_instruction_window_decoder_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/bfid_pkg.sv
sv/bfid_front.sv
sv/bfid_queue.sv
sv/bfid_back.sv
sv/bf_instruction_window_decoder_unit.sv
sim/bfid_window_monitor.sv
sim/tb.sv
